// ----- src/stream_find_replace_macros.svh -----
// Assertion macros shared by the find and replace block.
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define SFR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define SFR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A condition that holds in the cycle after its trigger.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/sfr_pkg.sv -----
// Types and constants shared by the find and replace block.
`timescale 1ns / 1ps

package sfr_pkg;

   // Sizes of the pattern, the replacement and the byte window.
   localparam int PATTERN_MAX = 8;
   localparam int REPLACE_MAX = 8;
   localparam int BYTE_W      = 8;
   localparam int WIN_DEPTH   = 8;
   localparam int WIN_BITS    = WIN_DEPTH * BYTE_W;
   localparam int LEN_W       = 4;
   localparam int IDX_W       = 3;
   localparam int WORD_W      = 64;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // Register indexes, taken from paddr[4:3].
   localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
   localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
   localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

   // One input item.
   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              carries_byte;
      logic              in_last;
   } sfr_in_type;

   // One result item.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_has_byte;
      logic              out_last;
   } sfr_out_type;

   // Configuration in force, lengths already saturated.
   typedef struct packed {
      logic [WORD_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]  pattern_length;
      logic [WORD_W-1:0] replacement_bytes;
      logic [LEN_W-1:0]  replacement_length;
   } sfr_cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load;
      logic             shift_one;
      logic             shift_pat;
      logic             produce_head;
      logic             produce_repl;
      logic             finish;
      logic             finish_last;
      logic [IDX_W-1:0] repl_idx;
   } sfr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic len_zero;
      logic len_full;
      logic match_full;
      logic match_prefix;
      logic produce_ok;
      logic out_free;
   } sfr_status_type;

endpackage

// ----- src/sfr_csr.sv -----
// Configuration registers with an APB-style access port.
`timescale 1ns / 1ps

module sfr_csr import sfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output sfr_cfg_type           cfg
);

   logic [WORD_W-1:0] pattern_bytes_ff;
   logic [LEN_W-1:0]  pattern_length_ff;
   logic [WORD_W-1:0] replacement_bytes_ff;
   logic [LEN_W-1:0]  replacement_length_ff;
   logic [1:0]        reg_idx;
   logic              wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;

   // Register writes in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= '0;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_PATTERN_BYTES:      pattern_bytes_ff      <= pwdata;
            REG_PATTERN_LENGTH:     pattern_length_ff     <= pwdata[LEN_W-1:0];
            REG_REPLACEMENT_BYTES:  replacement_bytes_ff  <= pwdata;
            REG_REPLACEMENT_LENGTH: replacement_length_ff <= pwdata[LEN_W-1:0];
         endcase
      end
   end

   // Read back of the raw register values.
   always_comb begin
      unique case (reg_idx)
         REG_PATTERN_BYTES:      prdata = pattern_bytes_ff;
         REG_PATTERN_LENGTH:     prdata = CSR_DATA_W'(pattern_length_ff);
         REG_REPLACEMENT_BYTES:  prdata = replacement_bytes_ff;
         REG_REPLACEMENT_LENGTH: prdata = CSR_DATA_W'(replacement_length_ff);
      endcase
   end

   // Lengths above the maximum count as the maximum.
   always_comb begin
      cfg.pattern_bytes      = pattern_bytes_ff;
      cfg.replacement_bytes  = replacement_bytes_ff;
      cfg.pattern_length     = (pattern_length_ff > LEN_W'(PATTERN_MAX)) ?
                               LEN_W'(PATTERN_MAX) : pattern_length_ff;
      cfg.replacement_length = (replacement_length_ff > LEN_W'(REPLACE_MAX)) ?
                               LEN_W'(REPLACE_MAX) : replacement_length_ff;
   end

endmodule

// ----- src/sfr_datapath.sv -----
// Byte window, pattern comparator and result staging of the find and replace block.
`timescale 1ns / 1ps

module sfr_datapath import sfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  sfr_cfg_type    cfg,
   input  sfr_in_type     req_data,
   input  sfr_cmd_type    cmd,
   output sfr_status_type status,
   output logic           rsp_valid,
   output sfr_out_type    rsp_data,
   input  logic           rsp_stall
);

`include "stream_find_replace_macros.svh"

   logic [WIN_BITS-1:0] win_ff, win_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [BYTE_W-1:0]   hold_ff, hold_in;
   logic                hold_valid_ff, hold_valid_in;
   sfr_out_type         out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic [LEN_W-1:0]    cmp_len;
   logic [WIN_DEPTH-1:0] byte_ok;
   logic                eq;
   logic                out_free;
   logic                produce;
   logic [BYTE_W-1:0]   produce_byte;

   // Compare the head of the window with the pattern over min(len, plen) bytes.
   always_comb begin
      cmp_len = (len_ff < cfg.pattern_length) ? len_ff : cfg.pattern_length;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         byte_ok[i] = (LEN_W'(i) >= cmp_len) ||
                      (win_ff[i*BYTE_W +: BYTE_W] == cfg.pattern_bytes[i*BYTE_W +: BYTE_W]);
      end
      eq = &byte_ok;
   end

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign produce      = cmd.produce_head || cmd.produce_repl;
   assign produce_byte = cmd.produce_head ? win_ff[BYTE_W-1:0] :
                         cfg.replacement_bytes[cmd.repl_idx*BYTE_W +: BYTE_W];

   always_comb begin
      status.len_zero     = (len_ff == '0);
      status.len_full     = (len_ff == LEN_W'(WIN_DEPTH));
      status.match_full   = (cfg.pattern_length != '0) && eq && (len_ff >= cfg.pattern_length);
      status.match_prefix = (cfg.pattern_length != '0) && eq && (len_ff < cfg.pattern_length);
      status.produce_ok   = !hold_valid_ff || out_free;
      status.out_free     = out_free;
   end

   // Window update: append the new byte, or drop bytes from the head.
   always_comb begin
      win_in = win_ff;
      len_in = len_ff;
      if (cmd.load) begin
         if (req_data.carries_byte) begin
            win_in[{len_ff[IDX_W-1:0], 3'b000} +: BYTE_W] = req_data.in_byte;
            len_in = len_ff + LEN_W'(1);
         end
      end else if (cmd.shift_one) begin
         win_in = win_ff >> BYTE_W;
         len_in = len_ff - LEN_W'(1);
      end else if (cmd.shift_pat) begin
         win_in = win_ff >> {cfg.pattern_length, 3'b000};
         len_in = len_ff - cfg.pattern_length;
      end
   end

   // Result staging: one result is held back so that the end flag can go on the final one.
   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      if (produce) begin
         if (hold_valid_ff) begin
            out_in       = '{out_byte: hold_ff, out_has_byte: 1'b1, out_last: 1'b0};
            out_valid_in = 1'b1;
         end
         hold_in       = produce_byte;
         hold_valid_in = 1'b1;
      end else if (cmd.finish) begin
         if (hold_valid_ff) begin
            out_in       = '{out_byte: hold_ff, out_has_byte: 1'b1,
                             out_last: cmd.finish_last};
            out_valid_in = 1'b1;
         end else if (cmd.finish_last) begin
            out_in       = '{out_byte: '0, out_has_byte: 1'b0, out_last: 1'b1};
            out_valid_in = 1'b1;
         end
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      win_ff  <= win_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `SFR_ASSERT_SAME(a_produce_has_room, produce, status.produce_ok,
                    "result produced with the staging slots full")
   `SFR_ASSERT_ALWAYS(a_len_in_range, len_ff <= LEN_W'(WIN_DEPTH),
                      "window count beyond the window depth")
   `SFR_ASSERT_NEXT(a_finish_empties_hold, cmd.finish, !hold_valid_ff,
                    "held result left behind at the end of an item")

endmodule

// ----- src/sfr_ctrl.sv -----
// Sequencer that steps the datapath through one item at a time.
`timescale 1ns / 1ps

module sfr_ctrl import sfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  sfr_cfg_type    cfg,
   input  logic           req_valid,
   input  sfr_in_type     req_data,
   output logic           req_stall,
   input  sfr_status_type status,
   output sfr_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPL,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   logic             last_ff, last_in;
   logic             flushing_ff, flushing_in;
   logic             repl_done;

   assign req_stall = (state_ff != ST_IDLE);
   assign repl_done = (({1'b0, ridx_ff} + LEN_W'(1)) == cfg.replacement_length);

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      ridx_in     = ridx_ff;
      last_in     = last_ff;
      flushing_in = flushing_ff;
      cmd             = '0;
      cmd.finish_last = last_ff;
      cmd.repl_idx    = ridx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load    = 1'b1;
               last_in     = req_data.in_last;
               flushing_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (status.len_zero) begin
               state_in = ST_FINISH;
            end else if (flushing_ff) begin
               if (status.produce_ok) begin
                  cmd.produce_head = 1'b1;
                  cmd.shift_one    = 1'b1;
               end
            end else if (status.match_full) begin
               cmd.shift_pat = 1'b1;
               ridx_in       = '0;
               if (cfg.replacement_length != '0) begin
                  state_in = ST_REPL;
               end else if (last_ff) begin
                  flushing_in = 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (status.match_prefix) begin
               // The rest may still start an occurrence: keep it, or flush at the end.
               if (last_ff) begin
                  flushing_in = 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               if (status.produce_ok) begin
                  cmd.produce_head = 1'b1;
                  cmd.shift_one    = 1'b1;
               end
            end
         end
         ST_REPL: begin
            if (status.produce_ok) begin
               cmd.produce_repl = 1'b1;
               if (repl_done) begin
                  if (last_ff) begin
                     flushing_in = 1'b1;
                     state_in    = ST_SCAN;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  ridx_in = ridx_ff + IDX_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish  = 1'b1;
               flushing_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ridx_ff     <= '0;
         last_ff     <= 1'b0;
         flushing_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ridx_ff     <= ridx_in;
         last_ff     <= last_in;
         flushing_ff <= flushing_in;
      end
   end

endmodule

// ----- src/stream_find_replace.sv -----
// The first result of an item is held in the staging register, then moves to the output register.
// The sequencer gives at most one result byte per cycle.
// Output stalls hold the sequencer; a new item is taken only when the previous one is done.
// Reset (synchronous, active high) empties the byte window, idles the sequencer and clears the
// configuration; the byte and result data registers keep their contents.
`timescale 1ns / 1ps

module stream_find_replace import sfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  sfr_in_type            req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output sfr_out_type           rsp_data,
   input  logic                  rsp_stall,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

`include "stream_find_replace_macros.svh"

   sfr_cfg_type    cfg;
   sfr_cmd_type    cmd;
   sfr_status_type status;

   // Configuration registers.
   sfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer.
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Window, comparator and result registers.
   sfr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   `SFR_ASSERT_SAME(a_idle_window_fits, !req_stall, !status.len_full,
                    "more bytes waiting than the partial match buffer holds")
   `SFR_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
                    "second item taken while the first is still in work")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the streaming find and replace block.
`timescale 1ns / 1ps

module tb;
   import sfr_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEM_TARGET  = 410;
   localparam int RESULT_CAP   = 17;

   // Kinds of row in the directed table, and how each item's results are known.
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_ONE} exp_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   reg_idx;
      logic [63:0]  value;
      sfr_in_type   item;
      exp_kind_type exp_kind;
      sfr_out_type  exp;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   sfr_in_type            req_data;
   logic                  req_stall;
   logic                  rsp_valid;
   sfr_out_type           rsp_data;
   logic                  rsp_stall;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predictor copy of the registers and of the waiting bytes.
   logic [63:0] pat_word;
   logic [3:0]  pat_len;
   logic [63:0] rep_word;
   logic [3:0]  rep_len;
   logic [7:0]  held_bytes [0:7];
   int          held_count;

   sfr_out_type expected_out [$];
   sfr_out_type step_out [$];
   dir_row_type directed_rows [$];

   int  mismatches;
   int  cycle_count;
   int  items_sent;
   bit  no_gaps;

   stream_find_replace dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Clock with a period of 4 ns.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Appends one passed-on or replacement byte to the results of the current item.
   function automatic void emit_byte(input logic [7:0] b);
      sfr_out_type r;
      r.out_byte     = b;
      r.out_has_byte = 1'b1;
      r.out_last     = 1'b0;
      if (step_out.size() < RESULT_CAP) begin
         step_out.push_back(r);
      end
   endfunction

   // Works out the results of one item and advances the waiting bytes.
   function automatic void replace_step(input sfr_in_type it);
      logic [7:0]  win [0:7];
      int          len;
      int          pos;
      int          m;
      int          plen;
      int          rlen;
      int          i;
      bit          eq;
      bit          settled;
      sfr_out_type r;
      step_out.delete();
      plen = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
      rlen = (rep_len > REPLACE_MAX) ? REPLACE_MAX : int'(rep_len);
      len = 0;
      pos = 0;
      settled = 1'b0;
      for (i = 0; i < held_count; i++) begin
         win[len] = held_bytes[i];
         len++;
      end
      if (it.carries_byte && len < 8) begin
         win[len] = it.in_byte;
         len++;
      end

      // Shift out bytes until the window is a pattern prefix or one match is replaced.
      while (len > 0 && !settled) begin
         if (plen > 0) begin
            m = (len < plen) ? len : plen;
            eq = 1'b1;
            for (i = 0; i < m; i++) begin
               if (win[pos+i] != pat_word[8*i +: 8]) eq = 1'b0;
            end
            if (eq && len >= plen) begin
               for (i = 0; i < rlen; i++) emit_byte(rep_word[8*i +: 8]);
               pos += plen;
               len -= plen;
               settled = 1'b1;
            end else if (eq) begin
               settled = 1'b1;
            end
         end
         if (!settled) begin
            emit_byte(win[pos]);
            pos++;
            len--;
         end
      end

      // At the end of the string the rest is flushed and the final result marked.
      if (it.in_last) begin
         while (len > 0) begin
            emit_byte(win[pos]);
            pos++;
            len--;
         end
         held_count = 0;
         if (step_out.size() > 0) begin
            step_out[step_out.size()-1].out_last = 1'b1;
         end else begin
            r.out_byte     = 8'h00;
            r.out_has_byte = 1'b0;
            r.out_last     = 1'b1;
            step_out.push_back(r);
         end
      end else begin
         if (len > 7) len = 7;
         for (i = 0; i < len; i++) held_bytes[i] = win[pos+i];
         held_count = len;
      end
   endfunction

   function automatic dir_row_type csr_row(input logic [1:0] idx, input logic [63:0] value);
      dir_row_type row;
      row = '0;
      row.kind    = ROW_CSR;
      row.reg_idx = idx;
      row.value   = value;
      return row;
   endfunction

   function automatic dir_row_type item_row(input logic [7:0] b, input logic carries,
                                            input logic last, input exp_kind_type ek,
                                            input sfr_out_type exp);
      dir_row_type row;
      row = '0;
      row.kind              = ROW_ITEM;
      row.item.in_byte      = b;
      row.item.carries_byte = carries;
      row.item.in_last      = last;
      row.exp_kind          = ek;
      row.exp               = exp;
      return row;
   endfunction

   task automatic flag_error(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $realtime, what);
   endtask

   // Presents one item after a random gap and records its expected results on acceptance.
   task automatic send_item(input sfr_in_type it, input exp_kind_type ek,
                            input sfr_out_type exp);
      while (!no_gaps && $urandom_range(0, 99) < 25) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      replace_step(it);
      case (ek)
         EXP_PREDICT: foreach (step_out[i]) expected_out.push_back(step_out[i]);
         EXP_ONE:     expected_out.push_back(exp);
         default:     ;
      endcase
      items_sent++;
   endtask

   // Holds the sender until every result is back and the block has gone quiet.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write: a setup cycle, then an access cycle.
   task automatic write_csr(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_PATTERN_BYTES:      pat_word = value;
         REG_PATTERN_LENGTH:     pat_len  = value[3:0];
         REG_REPLACEMENT_BYTES:  rep_word = value;
         REG_REPLACEMENT_LENGTH: rep_len  = value[3:0];
         default:                ;
      endcase
   endtask

   // Picks a new setting, with the extremes and out-of-range lengths now and then.
   task automatic write_random_config();
      logic [63:0] pw;
      logic [63:0] rw;
      int          pl;
      int          rl;
      int          b;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         pw = {$urandom, $urandom};
      end else if (r < 27) begin
         pw = '1;
      end else if (r < 32) begin
         pw = '0;
      end else begin
         for (b = 0; b < 8; b++) pw[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 2));
      end
      r = $urandom_range(0, 99);
      if (r < 8) pl = 0;
      else if (r < 18) pl = 8;
      else if (r < 28) pl = $urandom_range(9, 15);
      else if (r < 80) pl = $urandom_range(1, 3);
      else pl = $urandom_range(4, 7);
      r = $urandom_range(0, 99);
      if (r < 10) rw = '0;
      else if (r < 20) rw = '1;
      else rw = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 15) rl = 0;
      else if (r < 25) rl = 8;
      else if (r < 35) rl = $urandom_range(9, 15);
      else rl = $urandom_range(1, 7);
      write_csr(REG_PATTERN_BYTES, pw);
      write_csr(REG_PATTERN_LENGTH, 64'(pl));
      write_csr(REG_REPLACEMENT_BYTES, rw);
      write_csr(REG_REPLACEMENT_LENGTH, 64'(rl));
   endtask

   // Sends one string built mostly from the pattern, so that matches and broken matches occur.
   task automatic send_string(input int n_bytes, input bit close);
      sfr_in_type  it;
      sfr_out_type none;
      int          k;
      int          r;
      int          p;
      int          plen;
      bit          empty_end;
      none = '0;
      plen = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
      k = 0;
      empty_end = close && ($urandom_range(0, 99) < 15);
      for (p = 0; p < n_bytes; p++) begin
         r = $urandom_range(0, 99);
         if (plen > 0 && r < 60) begin
            it.in_byte = pat_word[8*k +: 8];
            k = (k + 1) % plen;
         end else if (r < 85) begin
            it.in_byte = 8'h61 + 8'($urandom_range(0, 2));
            k = 0;
         end else begin
            it.in_byte = 8'($urandom_range(0, 255));
            k = 0;
         end
         it.carries_byte = ($urandom_range(0, 99) >= 5);
         it.in_last      = close && !empty_end && (p == n_bytes - 1);
         send_item(it, EXP_PREDICT, none);
      end
      if (empty_end) begin
         it.in_byte      = 8'($urandom_range(0, 255));
         it.carries_byte = 1'b0;
         it.in_last      = 1'b1;
         send_item(it, EXP_PREDICT, none);
      end
   endtask

   // Result checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin : result_check
      sfr_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out.size() == 0) begin
            flag_error($sformatf("unexpected result byte=%h has_byte=%b last=%b",
                                 rsp_data.out_byte, rsp_data.out_has_byte,
                                 rsp_data.out_last));
         end else begin
            want = expected_out.pop_front();
            if (rsp_data.out_byte !== want.out_byte ||
                rsp_data.out_has_byte !== want.out_has_byte ||
                rsp_data.out_last !== want.out_last) begin
               flag_error($sformatf("expected byte=%h has_byte=%b last=%b, got %h %b %b",
                                    want.out_byte, want.out_has_byte, want.out_last,
                                    rsp_data.out_byte, rsp_data.out_has_byte,
                                    rsp_data.out_last));
            end
         end
      end
   end

   // Receiver stalls at random, except during the stretch without gaps.
   always @(negedge clock) begin
      rsp_stall <= no_gaps ? 1'b0 : ($urandom_range(0, 99) < 25);
   end

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stimulus: directed table first, then random phases under changing settings.
   initial begin : stimulus
      dir_row_type row;
      sfr_out_type none;
      int          phase;
      int          phase_items;
      int          target;
      int          i;
      bit          prev_csr;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      pat_word    = '0;
      pat_len     = '0;
      rep_word    = '0;
      rep_len     = '0;
      held_count  = 0;
      mismatches  = 0;
      cycle_count = 0;
      items_sent  = 0;
      no_gaps     = 1'b0;
      none        = '0;
      for (i = 0; i < 8; i++) held_bytes[i] = 8'h00;

      // Pass-through after reset: bytes come straight back, an empty end gives a bare marker.
      directed_rows.push_back(item_row(8'h00, 1'b1, 1'b0, EXP_ONE, '{8'h00, 1'b1, 1'b0}));
      directed_rows.push_back(item_row(8'hFF, 1'b1, 1'b1, EXP_ONE, '{8'hFF, 1'b1, 1'b1}));
      directed_rows.push_back(item_row(8'h00, 1'b0, 1'b1, EXP_ONE, '{8'h00, 1'b0, 1'b1}));
      directed_rows.push_back(item_row(8'h5A, 1'b0, 1'b0, EXP_NONE, none));
      // A short pattern with a longer replacement, including a shift after a broken match.
      directed_rows.push_back(csr_row(REG_PATTERN_BYTES, 64'h6261));
      directed_rows.push_back(csr_row(REG_PATTERN_LENGTH, 64'd2));
      directed_rows.push_back(csr_row(REG_REPLACEMENT_BYTES, 64'h5A5958));
      directed_rows.push_back(csr_row(REG_REPLACEMENT_LENGTH, 64'd3));
      directed_rows.push_back(item_row(8'h61, 1'b1, 1'b0, EXP_PREDICT, none));
      directed_rows.push_back(item_row(8'h62, 1'b1, 1'b0, EXP_PREDICT, none));
      directed_rows.push_back(item_row(8'h61, 1'b1, 1'b0, EXP_PREDICT, none));
      directed_rows.push_back(item_row(8'h61, 1'b1, 1'b0, EXP_PREDICT, none));
      directed_rows.push_back(item_row(8'h62, 1'b1, 1'b0, EXP_PREDICT, none));
      directed_rows.push_back(item_row(8'h61, 1'b1, 1'b1, EXP_PREDICT, none));
      // Oversized lengths saturate: an all-ones pattern of eight bytes becomes eight zeros.
      directed_rows.push_back(csr_row(REG_PATTERN_BYTES, '1));
      directed_rows.push_back(csr_row(REG_PATTERN_LENGTH, 64'd15));
      directed_rows.push_back(csr_row(REG_REPLACEMENT_BYTES, '0));
      directed_rows.push_back(csr_row(REG_REPLACEMENT_LENGTH, 64'd15));
      for (i = 0; i < 8; i++) begin
         directed_rows.push_back(item_row(8'hFF, 1'b1, 1'(i == 7), EXP_PREDICT, none));
      end
      // Bytes left waiting while the pattern shrinks to one byte and the replacement empties.
      for (i = 0; i < 3; i++) begin
         directed_rows.push_back(item_row(8'hFF, 1'b1, 1'b0, EXP_PREDICT, none));
      end
      directed_rows.push_back(csr_row(REG_PATTERN_LENGTH, 64'd1));
      directed_rows.push_back(csr_row(REG_REPLACEMENT_LENGTH, 64'd0));
      directed_rows.push_back(item_row(8'h00, 1'b0, 1'b0, EXP_PREDICT, none));
      directed_rows.push_back(item_row(8'h00, 1'b0, 1'b1, EXP_ONE, '{8'hFF, 1'b1, 1'b1}));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table.
      prev_csr = 1'b0;
      foreach (directed_rows[j]) begin
         row = directed_rows[j];
         case (row.kind)
            ROW_CSR: begin
               if (!prev_csr) wait_idle();
               write_csr(row.reg_idx, row.value);
               prev_csr = 1'b1;
            end
            default: begin
               send_item(row.item, row.exp_kind, row.exp);
               prev_csr = 1'b0;
            end
         endcase
      end

      // Random phases; one of them runs with no gaps on either side.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         write_random_config();
         no_gaps = (phase == 2);
         phase_items = items_sent;
         target = $urandom_range(15, 40);
         while (items_sent - phase_items < target) begin
            if ($urandom_range(0, 9) == 0) send_string($urandom_range(13, 20), 1'b1);
            else send_string($urandom_range(1, 12), 1'b1);
         end
         // Now and then a string is left open so the next setting meets waiting bytes.
         if ($urandom_range(0, 2) == 0) send_string($urandom_range(1, 7), 1'b0);
         no_gaps = 1'b0;
         phase++;
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
